// ----- src/mpd_pkg.sv -----
`timescale 1ns / 1ps
package mpd_pkg;
  localparam int MaxPoints = 1024;
  localparam int AddrW     = $clog2(MaxPoints);
  localparam int CountW    = AddrW + 1;
  localparam int DistW     = 32;
  localparam int RootW     = 24;
  localparam int BitW      = 5;

  typedef enum logic [2:0] {
    StIdle,
    StWrite,
    StScan,
    StSqrt,
    StDone
  } state_e;
endpackage

// ----- src/median_point_distance_unit.sv -----
`timescale 1ns / 1ps
// median point distance unit
// input channel: a point word (x_coord_i, y_coord_i, is_last_i) is taken at a
// rising edge with start_i high and busy_o low. points of a set may come one
// per cycle; each squared distance is written to a 1024-entry buffer in the
// cycle after it is taken. points beyond 1024 in a set are dropped.
// after the word marked last, busy_o stays high while the lower median is
// found by a bitwise radix search: 32 passes over the n stored words through
// the single buffer read port, then a 24-step square root on one 24x24
// multiplier.
// the result word (median_sq_dist_o, median_dist_fixed_o) is shown for one
// cycle with valid_o high; the receiver cannot stall and must take it then.
// busy_o falls in the cycle after the result, and a new set starts with a
// point count of zero.
// reset clears the sequencer and the point count; buffer contents stay
// undefined and are always written before they are read.
module median_point_distance_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic signed [15:0]          x_coord_i,
  input  logic signed [15:0]          y_coord_i,
  input  logic                        is_last_i,
  output logic                        valid_o,
  output logic [mpd_pkg::DistW-1:0]   median_sq_dist_o,
  output logic [mpd_pkg::RootW-1:0]   median_dist_fixed_o
);
  import mpd_pkg::*;

  state_e state_q, state_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [CountW-1:0] n_q, n_d;
  logic [CountW-1:0] k_q, k_d;
  logic [CountW-1:0] idx_q, idx_d;
  logic [CountW-1:0] lt_q, lt_d;
  logic [BitW-1:0]   bit_q, bit_d;
  logic [DistW-1:0]  ans_q, ans_d;
  logic [RootW-1:0]  root_q, root_d;
  logic              wr_pend_q, wr_pend_d;
  logic [AddrW-1:0]  wr_idx_q, wr_idx_d;
  logic signed [15:0] x_q, y_q;
  logic              rv_q;

  logic [DistW-1:0]  mem [MaxPoints];
  logic [DistW-1:0]  rdata_q;

  logic              accept;
  logic              rd_en;
  logic signed [31:0] xx, yy;
  logic [DistW-1:0]  dsum;
  logic [DistW-1:0]  trial;
  logic              hit;
  logic [CountW-1:0] cnt_now;
  logic [RootW-1:0]  rtrial;
  logic [2*RootW-1:0] rsq;
  logic [2*RootW-1:0] rtarget;

  assign accept = start_i && !busy_o;
  assign busy_o = (state_q != StIdle);
  assign valid_o = (state_q == StDone);
  assign median_sq_dist_o = ans_q;
  assign median_dist_fixed_o = root_q;

  assign xx = 32'(x_q) * 32'(x_q);
  assign yy = 32'(y_q) * 32'(y_q);
  assign dsum = xx + yy;

  assign trial = ans_q | (DistW'(1) << bit_q);
  assign hit = rv_q && (rdata_q < trial);
  assign cnt_now = lt_q + CountW'(hit);
  assign rd_en = (state_q == StScan) && (idx_q < n_q);

  assign rtrial = root_q | (RootW'(1) << bit_q);
  assign rsq = (2*RootW)'(rtrial) * (2*RootW)'(rtrial);
  assign rtarget = {ans_q, 16'b0};

  always_ff @(posedge clk_i) begin
    if (wr_pend_q) begin
      mem[wr_idx_q] <= dsum;
    end
    rdata_q <= mem[idx_q[AddrW-1:0]];
    if (accept) begin
      x_q <= x_coord_i;
      y_q <= y_coord_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      cnt_q     <= '0;
      n_q       <= '0;
      k_q       <= '0;
      idx_q     <= '0;
      lt_q      <= '0;
      bit_q     <= '0;
      ans_q     <= '0;
      root_q    <= '0;
      wr_pend_q <= 1'b0;
      wr_idx_q  <= '0;
      rv_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      n_q       <= n_d;
      k_q       <= k_d;
      idx_q     <= idx_d;
      lt_q      <= lt_d;
      bit_q     <= bit_d;
      ans_q     <= ans_d;
      root_q    <= root_d;
      wr_pend_q <= wr_pend_d;
      wr_idx_q  <= wr_idx_d;
      rv_q      <= rd_en;
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    n_d       = n_q;
    k_d       = k_q;
    idx_d     = idx_q;
    lt_d      = lt_q;
    bit_d     = bit_q;
    ans_d     = ans_q;
    root_d    = root_q;
    wr_pend_d = 1'b0;
    wr_idx_d  = wr_idx_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (cnt_q < CountW'(MaxPoints)) begin
            wr_pend_d = 1'b1;
            wr_idx_d  = cnt_q[AddrW-1:0];
            cnt_d     = cnt_q + 1'b1;
          end
          if (is_last_i) begin
            n_d     = (cnt_q < CountW'(MaxPoints)) ? cnt_q + 1'b1 : cnt_q;
            cnt_d   = '0;
            state_d = StWrite;
          end
        end
      end
      StWrite: begin
        k_d     = CountW'(({1'b0, n_q} + 1'b1) >> 1);
        idx_d   = '0;
        lt_d    = '0;
        ans_d   = '0;
        bit_d   = BitW'(DistW - 1);
        state_d = StScan;
      end
      StScan: begin
        if (idx_q == n_q) begin
          if (cnt_now < k_q) begin
            ans_d = trial;
          end
          idx_d = '0;
          lt_d  = '0;
          if (bit_q == '0) begin
            bit_d   = BitW'(RootW - 1);
            root_d  = '0;
            state_d = StSqrt;
          end else begin
            bit_d = bit_q - 1'b1;
          end
        end else begin
          idx_d = idx_q + 1'b1;
          lt_d  = cnt_now;
        end
      end
      StSqrt: begin
        if (rsq <= rtarget) begin
          root_d = rtrial;
        end
        if (bit_q == '0) begin
          state_d = StDone;
        end else begin
          bit_d = bit_q - 1'b1;
        end
      end
      StDone: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end
endmodule
